### src/tdps_pkg.sv
// Shared widths, register map, reset values and types for the tank drive controller.
`default_nettype none

package tdps_pkg;

    // Field widths of the words on the channels
    localparam int POS_IN_WIDTH  = 24;
    localparam int DIST_WIDTH    = 23;
    localparam int LIMIT_WIDTH   = 7;
    localparam int DRIVE_WIDTH   = 8;
    localparam int MEAN_WIDTH    = 24;

    // Configuration register widths
    localparam int GAIN_WIDTH    = 16;
    localparam int SLEW_WIDTH    = 7;
    localparam int SETTLE_WIDTH  = 10;
    localparam int STALL_WIDTH   = 8;

    // Default internal position width
    localparam int POS_WIDTH_DEF = 24;

    // APB port
    localparam int APB_ADDR_WIDTH = 5;
    localparam int APB_DATA_WIDTH = 32;

    // Register reset values
    localparam logic [GAIN_WIDTH-1:0]   GAIN_STRAIGHT_RST = 16'd38;
    localparam logic [GAIN_WIDTH-1:0]   GAIN_TURN_RST     = 16'd179;
    localparam logic [SLEW_WIDTH-1:0]   SLEW_STRAIGHT_RST = 7'd5;
    localparam logic [SLEW_WIDTH-1:0]   SLEW_TURN_RST     = 7'd4;
    localparam logic [SETTLE_WIDTH-1:0] SETTLE_BOUND_RST  = 10'd5;
    localparam logic [STALL_WIDTH-1:0]  STALL_LIMIT_RST   = 8'd10;

    localparam logic [STALL_WIDTH-1:0]  STALL_MAX         = 8'd255;

    // Command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        REG_GAIN_STRAIGHT = 3'd0,
        REG_GAIN_TURN     = 3'd1,
        REG_SLEW_STRAIGHT = 3'd2,
        REG_SLEW_TURN     = 3'd3,
        REG_SETTLE_BOUND  = 3'd4,
        REG_STALL_LIMIT   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0]   gain_straight;
        logic [GAIN_WIDTH-1:0]   gain_turn;
        logic [SLEW_WIDTH-1:0]   slew_straight;
        logic [SLEW_WIDTH-1:0]   slew_turn;
        logic [SETTLE_WIDTH-1:0] settle_bound;
        logic [STALL_WIDTH-1:0]  stall_limit;
    } cfg_t;

endpackage

`default_nettype wire

### src/tdps_if.sv
// Valid/ready channel interfaces for sample words and drive result words.
`default_nettype none

interface tdps_in_if;
    import tdps_pkg::*;

    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic signed [POS_IN_WIDTH-1:0] left_position;
    logic signed [POS_IN_WIDTH-1:0] right_position;
    logic signed [DIST_WIDTH-1:0]   left_distance;
    logic signed [DIST_WIDTH-1:0]   right_distance;
    logic [LIMIT_WIDTH-1:0]         drive_limit;

    modport source (
        output valid, cmd, left_position, right_position,
               left_distance, right_distance, drive_limit,
        input  ready
    );

    modport sink (
        input  valid, cmd, left_position, right_position,
               left_distance, right_distance, drive_limit,
        output ready
    );
endinterface

interface tdps_out_if;
    import tdps_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [DRIVE_WIDTH-1:0] left_drive;
    logic signed [DRIVE_WIDTH-1:0] right_drive;
    logic                          move_done;
    logic [MEAN_WIDTH-1:0]         mean_error;

    modport source (
        output valid, left_drive, right_drive, move_done, mean_error,
        input  ready
    );

    modport sink (
        input  valid, left_drive, right_drive, move_done, mean_error,
        output ready
    );
endinterface

`default_nettype wire

### src/tdps_regs.sv
// APB configuration registers of the tank drive controller.
`default_nettype none

module tdps_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tdps_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  wire logic [tdps_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic      [tdps_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                      pready,
    output tdps_pkg::cfg_t                            cfg
);
    import tdps_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_WIDTH-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_GAIN_STRAIGHT: cfg_next.gain_straight = pwdata[GAIN_WIDTH-1:0];
                REG_GAIN_TURN:     cfg_next.gain_turn     = pwdata[GAIN_WIDTH-1:0];
                REG_SLEW_STRAIGHT: cfg_next.slew_straight = pwdata[SLEW_WIDTH-1:0];
                REG_SLEW_TURN:     cfg_next.slew_turn     = pwdata[SLEW_WIDTH-1:0];
                REG_SETTLE_BOUND:  cfg_next.settle_bound  = pwdata[SETTLE_WIDTH-1:0];
                REG_STALL_LIMIT:   cfg_next.stall_limit   = pwdata[STALL_WIDTH-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GAIN_STRAIGHT: prdata = APB_DATA_WIDTH'(cfg_reg.gain_straight);
            REG_GAIN_TURN:     prdata = APB_DATA_WIDTH'(cfg_reg.gain_turn);
            REG_SLEW_STRAIGHT: prdata = APB_DATA_WIDTH'(cfg_reg.slew_straight);
            REG_SLEW_TURN:     prdata = APB_DATA_WIDTH'(cfg_reg.slew_turn);
            REG_SETTLE_BOUND:  prdata = APB_DATA_WIDTH'(cfg_reg.settle_bound);
            REG_STALL_LIMIT:   prdata = APB_DATA_WIDTH'(cfg_reg.stall_limit);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_straight <= GAIN_STRAIGHT_RST;
            cfg_reg.gain_turn     <= GAIN_TURN_RST;
            cfg_reg.slew_straight <= SLEW_STRAIGHT_RST;
            cfg_reg.slew_turn     <= SLEW_TURN_RST;
            cfg_reg.settle_bound  <= SETTLE_BOUND_RST;
            cfg_reg.stall_limit   <= STALL_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### src/tdps_drive.sv
// One wheel's drive value: error times Q8.8 gain, limited to the slew cap with the error's sign.
`default_nettype none

module tdps_drive #(
    parameter int POSITION_WIDTH = tdps_pkg::POS_WIDTH_DEF
) (
    input  wire logic [POSITION_WIDTH-1:0]             mag,
    input  wire logic                                  neg,
    input  wire logic [tdps_pkg::GAIN_WIDTH-1:0]       gain,
    input  wire logic [tdps_pkg::LIMIT_WIDTH-1:0]      cap,
    output logic signed [tdps_pkg::DRIVE_WIDTH-1:0]    drive
);
    import tdps_pkg::*;

    localparam int PROD_WIDTH  = POSITION_WIDTH + GAIN_WIDTH;
    localparam int SCALE_WIDTH = PROD_WIDTH - 8;

    logic [PROD_WIDTH-1:0]  product;
    logic [SCALE_WIDTH-1:0] scaled;
    logic [LIMIT_WIDTH-1:0] level;

    always_comb
    begin
        product = PROD_WIDTH'(mag) * PROD_WIDTH'(gain);
        // drop the eight fraction bits: truncates the magnitude toward zero
        scaled  = product[PROD_WIDTH-1:8];
        if (scaled > SCALE_WIDTH'(cap))
            level = cap;
        else
            level = scaled[LIMIT_WIDTH-1:0];
        if (neg)
            drive = -DRIVE_WIDTH'(level);
        else
            drive = DRIVE_WIDTH'(level);
    end

endmodule

`default_nettype wire

### src/tdps_core.sv
// Input register, move state, control arithmetic and result register.
`default_nettype none

module tdps_core #(
    parameter int POSITION_WIDTH = tdps_pkg::POS_WIDTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tdps_pkg::cfg_t cfg,
    tdps_in_if.sink             in_ch,
    tdps_out_if.source          out_ch
);
    import tdps_pkg::*;

    localparam int PW = POSITION_WIDTH;

    // input register
    logic                           a_valid_reg;
    logic                           a_cmd_reg;
    logic signed [POS_IN_WIDTH-1:0] a_lpos_reg;
    logic signed [POS_IN_WIDTH-1:0] a_rpos_reg;
    logic signed [DIST_WIDTH-1:0]   a_ldist_reg;
    logic signed [DIST_WIDTH-1:0]   a_rdist_reg;
    logic [LIMIT_WIDTH-1:0]         a_limit_reg;

    // move state
    logic signed [PW-1:0]     goal_left_reg,  goal_left_next;
    logic signed [PW-1:0]     goal_right_reg, goal_right_next;
    logic [LIMIT_WIDTH-1:0]   slew_cap_reg,   slew_cap_next;
    logic [LIMIT_WIDTH-1:0]   move_limit_reg, move_limit_next;
    logic [PW-1:0]            prev_error_reg, prev_error_next;
    logic [STALL_WIDTH-1:0]   stall_count_reg, stall_count_next;
    logic                     active_reg,     active_next;

    // result register
    logic                          out_valid_reg;
    logic signed [DRIVE_WIDTH-1:0] left_drive_reg,  left_drive_next;
    logic signed [DRIVE_WIDTH-1:0] right_drive_reg, right_drive_next;
    logic                          move_done_reg,   move_done_next;
    logic [MEAN_WIDTH-1:0]         mean_error_reg,  mean_error_next;

    logic in_fire;
    logic result_free;
    logic advance;

    logic signed [PW-1:0]   lpos, rpos;
    logic signed [PW-1:0]   err_l, err_r;
    logic [PW-1:0]          abs_l, abs_r;
    logic [PW:0]            abs_sum;
    logic [PW-1:0]          mean;
    logic                   zero_l, zero_r;
    logic                   straight;
    logic [GAIN_WIDTH-1:0]  gain;
    logic [LIMIT_WIDTH:0]   cap_sum;
    logic [LIMIT_WIDTH-1:0] cap;
    logic [STALL_WIDTH-1:0] stall_step;
    logic [PW-1:0]          settle;
    logic                   finish;
    logic signed [DRIVE_WIDTH-1:0] drv_l, drv_r;

    assign result_free = !out_valid_reg || out_ch.ready;
    assign advance     = a_valid_reg && result_free;
    assign in_ch.ready = !a_valid_reg || result_free;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.left_drive  = left_drive_reg;
    assign out_ch.right_drive = right_drive_reg;
    assign out_ch.move_done   = move_done_reg;
    assign out_ch.mean_error  = mean_error_reg;

    // wheel errors and their mean magnitude
    always_comb
    begin
        lpos    = PW'(a_lpos_reg);
        rpos    = PW'(a_rpos_reg);
        err_l   = goal_left_reg - lpos;
        err_r   = goal_right_reg - rpos;
        abs_l   = err_l[PW-1] ? -err_l : err_l;
        abs_r   = err_r[PW-1] ? -err_r : err_r;
        abs_sum = {1'b0, abs_l} + {1'b0, abs_r};
        mean    = abs_sum[PW:1];
        zero_l  = (err_l == '0);
        zero_r  = (err_r == '0);
        // zero has a sign of its own
        straight = (zero_l && zero_r) ||
                   (!zero_l && !zero_r && (err_l[PW-1] == err_r[PW-1]));
        gain     = straight ? cfg.gain_straight : cfg.gain_turn;
        cap_sum  = {1'b0, slew_cap_reg} +
                   {1'b0, (straight ? cfg.slew_straight : cfg.slew_turn)};
        if (cap_sum > {1'b0, move_limit_reg})
            cap = move_limit_reg;
        else
            cap = cap_sum[LIMIT_WIDTH-1:0];
        if (prev_error_reg != mean)
            stall_step = '0;
        else if (stall_count_reg == STALL_MAX)
            stall_step = STALL_MAX;
        else
            stall_step = stall_count_reg + 1'b1;
        settle = PW'(cfg.settle_bound);
        finish = ((prev_error_reg < settle) && (mean < settle)) ||
                 (stall_step >= cfg.stall_limit);
    end

    tdps_drive #(.POSITION_WIDTH(PW)) u_drive_l (
        .mag   (abs_l),
        .neg   (err_l[PW-1]),
        .gain  (gain),
        .cap   (cap),
        .drive (drv_l)
    );

    tdps_drive #(.POSITION_WIDTH(PW)) u_drive_r (
        .mag   (abs_r),
        .neg   (err_r[PW-1]),
        .gain  (gain),
        .cap   (cap),
        .drive (drv_r)
    );

    // next state and result word
    always_comb
    begin
        goal_left_next   = goal_left_reg;
        goal_right_next  = goal_right_reg;
        slew_cap_next    = slew_cap_reg;
        move_limit_next  = move_limit_reg;
        prev_error_next  = prev_error_reg;
        stall_count_next = stall_count_reg;
        active_next      = active_reg;
        left_drive_next  = '0;
        right_drive_next = '0;
        move_done_next   = 1'b0;
        mean_error_next  = '0;

        if (a_cmd_reg == CMD_START)
        begin
            goal_left_next   = lpos + PW'(a_ldist_reg);
            goal_right_next  = rpos + PW'(a_rdist_reg);
            move_limit_next  = a_limit_reg;
            slew_cap_next    = '0;
            prev_error_next  = '0;
            stall_count_next = '0;
            active_next      = 1'b1;
        end
        else if (active_reg)
        begin
            slew_cap_next    = cap;
            stall_count_next = stall_step;
            mean_error_next  = MEAN_WIDTH'(mean);
            if (finish)
            begin
                move_done_next = 1'b1;
                active_next    = 1'b0;
            end
            else
            begin
                left_drive_next  = drv_l;
                right_drive_next = drv_r;
                prev_error_next  = mean;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            goal_left_reg   <= '0;
            goal_right_reg  <= '0;
            slew_cap_reg    <= '0;
            move_limit_reg  <= '0;
            prev_error_reg  <= '0;
            stall_count_reg <= '0;
            active_reg      <= 1'b0;
        end
        else
        begin
            if (in_fire)
                a_valid_reg <= 1'b1;
            else if (advance)
                a_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                goal_left_reg   <= goal_left_next;
                goal_right_reg  <= goal_right_next;
                slew_cap_reg    <= slew_cap_next;
                move_limit_reg  <= move_limit_next;
                prev_error_reg  <= prev_error_next;
                stall_count_reg <= stall_count_next;
                active_reg      <= active_next;
            end
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_cmd_reg   <= in_ch.cmd;
            a_lpos_reg  <= in_ch.left_position;
            a_rpos_reg  <= in_ch.right_position;
            a_ldist_reg <= in_ch.left_distance;
            a_rdist_reg <= in_ch.right_distance;
            a_limit_reg <= in_ch.drive_limit;
        end
        if (advance)
        begin
            left_drive_reg  <= left_drive_next;
            right_drive_reg <= right_drive_next;
            move_done_reg   <= move_done_next;
            mean_error_reg  <= mean_error_next;
        end
    end

endmodule

`default_nettype wire

### src/tank_drive_p_slew_controller.sv
// Top level of the two-wheel proportional drive controller with slew limit.
// Usage:
//   in_ch  (sink)   : one word per command. cmd = start latches the wheel goals
//                     (position plus distance) and the drive limit; cmd = sample
//                     runs one control step on the current encoder positions.
//   out_ch (source) : exactly one word per input word, in order: left/right
//                     drive, move_done and mean_error. Start words and samples
//                     taken while no move is running give zero drive.
//   APB port        : six registers at byte addresses 0,4,..,20 (gains, slew
//                     steps, settle bound, stall limit); write only while idle.
// Path: a word accepted into the input register moves on to the result register
//   once that is free, and its result word is taken from there.
// Throughput: one word per cycle while out_ch.ready stays high; the move state is
//   updated as a word moves into the result register, and the next word sees it.
// Reset: registers return to their defaults, no move is running, both stages
//   are empty.
// Receiver stall: the result word holds; the input register keeps accepting
//   until it is full as well, then in_ch.ready drops.
`default_nettype none

module tank_drive_p_slew_controller #(
    parameter int POSITION_WIDTH = tdps_pkg::POS_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tdps_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  wire logic [tdps_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic      [tdps_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                      pready,
    tdps_in_if.sink                                   in_ch,
    tdps_out_if.source                                out_ch
);
    import tdps_pkg::*;

    cfg_t cfg;

    tdps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tdps_core #(.POSITION_WIDTH(POSITION_WIDTH)) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

### src/tdps_checker.sv
// Port-level checks of the tank drive controller and their binding to the top level.
`default_nettype none

module tdps_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  in_valid,
    input wire logic                                  in_ready,
    input wire logic                                  out_valid,
    input wire logic                                  out_ready,
    input wire logic signed [tdps_pkg::DRIVE_WIDTH-1:0] left_drive,
    input wire logic signed [tdps_pkg::DRIVE_WIDTH-1:0] right_drive,
    input wire logic                                  move_done
);
    import tdps_pkg::*;

    localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_NEG_FULL = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};

    // result word holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // a fresh result follows an accepted word through the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result word without matching input word");

    // finishing sample stops both motors
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_done |-> (left_drive == '0) && (right_drive == '0))
        else $error("nonzero drive on finishing sample");

    // drive magnitude never exceeds full scale
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_drive != DRIVE_NEG_FULL) && (right_drive != DRIVE_NEG_FULL))
        else $error("drive out of range");

endmodule

bind tank_drive_p_slew_controller tdps_checker u_tdps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .left_drive  (out_ch.left_drive),
    .right_drive (out_ch.right_drive),
    .move_done   (out_ch.move_done)
);

`default_nettype wire

### verif/tank_drive_p_slew_controller_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tank drive controller: directed and random moves vs. a predictor.
module tank_drive_p_slew_controller_test;
    import tdps_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 7;
    localparam int DRAIN_GAP        = 4;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MOVE_SAMPLES_MAX = 40;
    localparam int HOLDOFF_CYCLES   = 120;
    localparam int POS_MAX          = 2 ** (POS_IN_WIDTH - 1) - 1;
    localparam int POS_MIN          = -(2 ** (POS_IN_WIDTH - 1));
    localparam int DIST_MAX         = 2 ** (DIST_WIDTH - 1) - 1;
    localparam int DIST_MIN         = -(2 ** (DIST_WIDTH - 1));
    localparam int LIMIT_MAX        = 2 ** LIMIT_WIDTH - 1;
    localparam int GAIN_MAX         = 2 ** GAIN_WIDTH - 1;
    localparam int SLEW_MAX         = 2 ** SLEW_WIDTH - 1;
    localparam int SETTLE_MAX       = 2 ** SETTLE_WIDTH - 1;

    typedef struct {
        logic                           cmd;
        logic signed [POS_IN_WIDTH-1:0] left_position;
        logic signed [POS_IN_WIDTH-1:0] right_position;
        logic signed [DIST_WIDTH-1:0]   left_distance;
        logic signed [DIST_WIDTH-1:0]   right_distance;
        logic [LIMIT_WIDTH-1:0]         drive_limit;
    } drive_word_t;

    typedef struct {
        logic signed [DRIVE_WIDTH-1:0] left_drive;
        logic signed [DRIVE_WIDTH-1:0] right_drive;
        logic                          move_done;
        logic [MEAN_WIDTH-1:0]         mean_error;
    } drive_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    tdps_in_if  in_ch ();
    tdps_out_if out_ch ();

    tank_drive_p_slew_controller #(
        .POSITION_WIDTH(POS_WIDTH_DEF)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Controller state as the testbench tracks it
    cfg_t                           ctl_cfg;
    logic signed [POS_IN_WIDTH-1:0] goal_l;
    logic signed [POS_IN_WIDTH-1:0] goal_r;
    int                             cap_now;
    int                             limit_now;
    longint                         last_mean;
    int                             same_count;
    bit                             moving;

    drive_result_t                  pending_drives[$];
    int                             mismatches;
    int                             send_idle_pct;
    int                             recv_idle_pct;
    int                             hold_cycles;
    // Simulated encoder counts of the two wheels
    logic signed [POS_IN_WIDTH-1:0] wheel_l;
    logic signed [POS_IN_WIDTH-1:0] wheel_r;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Result receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ch.ready = 1'b0;
                hold_cycles--;
            end
            else
                out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic int sign_of(input longint v);
        return int'(v > 0) - int'(v < 0);
    endfunction

    function automatic logic signed [DRIVE_WIDTH-1:0] wheel_drive(input longint err,
                                                                  input int gain,
                                                                  input int cap);
        longint mag;
        longint v;
        mag = (err < 0) ? -err : err;
        v = (mag * gain) >> 8;
        if (v > cap)
            v = cap;
        if (err < 0)
            return DRIVE_WIDTH'(-v);
        return DRIVE_WIDTH'(v);
    endfunction

    // One control step: update tracked state and return the expected result word
    function automatic drive_result_t control_step(input drive_word_t w);
        drive_result_t                  r;
        logic signed [POS_IN_WIDTH-1:0] err_l;
        logic signed [POS_IN_WIDTH-1:0] err_r;
        longint                         el;
        longint                         er;
        longint                         mean;
        longint                         settle;
        bit                             straight;
        int                             gain;
        int                             cap;
        r.left_drive  = '0;
        r.right_drive = '0;
        r.move_done   = 1'b0;
        r.mean_error  = '0;
        if (w.cmd == CMD_START)
        begin
            goal_l     = w.left_position + w.left_distance;
            goal_r     = w.right_position + w.right_distance;
            limit_now  = int'(w.drive_limit);
            cap_now    = 0;
            last_mean  = 0;
            same_count = 0;
            moving     = 1'b1;
        end
        else if (moving)
        begin
            err_l    = goal_l - w.left_position;
            err_r    = goal_r - w.right_position;
            el       = longint'(err_l);
            er       = longint'(err_r);
            mean     = (((el < 0) ? -el : el) + ((er < 0) ? -er : er)) >> 1;
            straight = (sign_of(el) == sign_of(er));
            gain     = straight ? int'(ctl_cfg.gain_straight) : int'(ctl_cfg.gain_turn);
            cap      = cap_now + (straight ? int'(ctl_cfg.slew_straight)
                                           : int'(ctl_cfg.slew_turn));
            if (cap > limit_now)
                cap = limit_now;
            cap_now       = cap;
            r.left_drive  = wheel_drive(el, gain, cap);
            r.right_drive = wheel_drive(er, gain, cap);
            r.mean_error  = mean[MEAN_WIDTH-1:0];

            if (last_mean == mean)
            begin
                if (same_count < int'(STALL_MAX))
                    same_count++;
            end
            else
                same_count = 0;

            settle = longint'(ctl_cfg.settle_bound);
            if ((last_mean < settle && mean < settle) ||
                same_count >= int'(ctl_cfg.stall_limit))
            begin
                r.left_drive  = '0;
                r.right_drive = '0;
                r.move_done   = 1'b1;
                moving        = 1'b0;
            end
            else
                last_mean = mean;
        end
        return r;
    endfunction

    function automatic drive_word_t start_word(input int lp, input int rp, input int ld,
                                               input int rd, input int lim);
        drive_word_t w;
        w.cmd            = CMD_START;
        w.left_position  = POS_IN_WIDTH'(lp);
        w.right_position = POS_IN_WIDTH'(rp);
        w.left_distance  = DIST_WIDTH'(ld);
        w.right_distance = DIST_WIDTH'(rd);
        w.drive_limit    = LIMIT_WIDTH'(lim);
        return w;
    endfunction

    function automatic drive_word_t sample_word(input int lp, input int rp);
        drive_word_t w;
        // distance and limit fields carry junk on samples; they must be ignored
        w                = start_word(lp, rp, $urandom, $urandom, $urandom);
        w.cmd            = CMD_SAMPLE;
        return w;
    endfunction

    function automatic int random_distance();
        if ($urandom_range(4) == 0)
            return int'($urandom);
        return int'($urandom_range(4000)) - 2000;
    endfunction

    function automatic logic signed [POS_IN_WIDTH-1:0] wheel_advance(
        input logic signed [POS_IN_WIDTH-1:0] pos,
        input logic signed [POS_IN_WIDTH-1:0] goal);
        logic signed [POS_IN_WIDTH-1:0] err;
        int                             p;
        int                             k;
        err = goal - pos;
        p   = $urandom_range(99);
        k   = $urandom_range(1, 4);
        if (p < 15)
            return pos;
        else if (p < 22)
            return POS_IN_WIDTH'($urandom);
        else if (p < 35)
            return POS_IN_WIDTH'(pos + (int'($urandom_range(6)) - 3));
        return POS_IN_WIDTH'(pos + err / k);
    endfunction

    function automatic int pick_value(input int lo, input int hi, input int typical_hi);
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return lo;
        else if (r == 1)
            return hi;
        return $urandom_range(lo, typical_hi);
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        drive_result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_drives.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result word: left %0d right %0d done %0b mean %0d",
                         $time, out_ch.left_drive, out_ch.right_drive, out_ch.move_done,
                         out_ch.mean_error);
            end
            else
            begin
                want = pending_drives.pop_front();
                check_field("left_drive", 64'(want.left_drive), 64'(out_ch.left_drive));
                check_field("right_drive", 64'(want.right_drive), 64'(out_ch.right_drive));
                check_field("move_done", {63'd0, want.move_done}, {63'd0, out_ch.move_done});
                check_field("mean_error", {40'd0, want.mean_error}, {40'd0, out_ch.mean_error});
            end
        end
    end

    // Offer one word at the falling edge and hold it until the block takes it
    task automatic send_word(input drive_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.cmd            = w.cmd;
        in_ch.left_position  = w.left_position;
        in_ch.right_position = w.right_position;
        in_ch.left_distance  = w.left_distance;
        in_ch.right_distance = w.right_distance;
        in_ch.drive_limit    = w.drive_limit;
        in_ch.valid          = 1'b1;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        pending_drives.push_back(control_step(w));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending_drives.size() != 0)
            @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    // APB write, then read back the same register
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_WIDTH-1:0] value);
        logic [APB_DATA_WIDTH-1:0] kept;
        case (idx)
            REG_GAIN_STRAIGHT:
            begin
                ctl_cfg.gain_straight = value[GAIN_WIDTH-1:0];
                kept = APB_DATA_WIDTH'(ctl_cfg.gain_straight);
            end
            REG_GAIN_TURN:
            begin
                ctl_cfg.gain_turn = value[GAIN_WIDTH-1:0];
                kept = APB_DATA_WIDTH'(ctl_cfg.gain_turn);
            end
            REG_SLEW_STRAIGHT:
            begin
                ctl_cfg.slew_straight = value[SLEW_WIDTH-1:0];
                kept = APB_DATA_WIDTH'(ctl_cfg.slew_straight);
            end
            REG_SLEW_TURN:
            begin
                ctl_cfg.slew_turn = value[SLEW_WIDTH-1:0];
                kept = APB_DATA_WIDTH'(ctl_cfg.slew_turn);
            end
            REG_SETTLE_BOUND:
            begin
                ctl_cfg.settle_bound = value[SETTLE_WIDTH-1:0];
                kept = APB_DATA_WIDTH'(ctl_cfg.settle_bound);
            end
            default:
            begin
                ctl_cfg.stall_limit = value[STALL_WIDTH-1:0];
                kept = APB_DATA_WIDTH'(ctl_cfg.stall_limit);
            end
        endcase
        paddr   = {idx, 2'b00};
        pwdata  = value;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== kept)
        begin
            mismatches++;
            $display("%0t: register %s read expected %0d got %0d",
                     $time, idx.name(), kept, prdata);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_config(input int g_s, input int g_t, input int s_s, input int s_t,
                              input int settle, input int stall);
        wait_drained();
        write_reg(REG_GAIN_STRAIGHT, g_s);
        write_reg(REG_GAIN_TURN, g_t);
        write_reg(REG_SLEW_STRAIGHT, s_s);
        write_reg(REG_SLEW_TURN, s_t);
        write_reg(REG_SETTLE_BOUND, settle);
        write_reg(REG_STALL_LIMIT, stall);
    endtask

    // Mostly well-formed moves (start, then samples that close in on the goal),
    // with some stray words and abandoned moves mixed in
    task automatic run_moves(input int n);
        drive_word_t w;
        int          sent;
        int          k;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(99) < 8)
            begin
                w.cmd            = 1'($urandom_range(1));
                w.left_position  = POS_IN_WIDTH'($urandom);
                w.right_position = POS_IN_WIDTH'($urandom);
                w.left_distance  = DIST_WIDTH'($urandom);
                w.right_distance = DIST_WIDTH'($urandom);
                w.drive_limit    = LIMIT_WIDTH'($urandom);
                send_word(w);
                sent++;
            end
            else
            begin
                if ($urandom_range(1) == 1)
                begin
                    wheel_l = POS_IN_WIDTH'($urandom);
                    wheel_r = POS_IN_WIDTH'($urandom);
                end
                send_word(start_word(int'(wheel_l), int'(wheel_r), random_distance(),
                                     random_distance(), int'($urandom_range(LIMIT_MAX))));
                sent++;
                for (k = 0; k < MOVE_SAMPLES_MAX && moving && sent < n; k++)
                begin
                    if ($urandom_range(99) < 3)
                        break;
                    wheel_l = wheel_advance(wheel_l, goal_l);
                    wheel_r = wheel_advance(wheel_r, goal_r);
                    send_word(sample_word(int'(wheel_l), int'(wheel_r)));
                    sent++;
                end
            end
        end
    endtask

    task automatic random_config();
        set_config(pick_value(0, GAIN_MAX, 1023), pick_value(0, GAIN_MAX, 1023),
                   pick_value(0, SLEW_MAX, SLEW_MAX), pick_value(0, SLEW_MAX, SLEW_MAX),
                   pick_value(0, SETTLE_MAX, 64), pick_value(1, int'(STALL_MAX), 20));
    endtask

    task automatic test_idle_sample();
        send_word(sample_word(123, -456));
    endtask

    task automatic test_field_extremes();
        send_word(start_word(POS_MAX, POS_MIN, DIST_MAX, DIST_MIN, LIMIT_MAX));
        send_word(sample_word(POS_MIN, POS_MAX));
        send_word(start_word(0, 0, 0, 0, 0));
        // error of the most negative count on both wheels, then one wheel at goal
        send_word(sample_word(POS_MIN, POS_MIN));
        send_word(sample_word(POS_MIN, 0));
    endtask

    task automatic test_settle_at_once();
        send_word(start_word(100, 200, 0, 0, 50));
        send_word(sample_word(100, 200));
    endtask

    task automatic test_turn_and_straight();
        send_word(start_word(0, 0, 1000, -1000, LIMIT_MAX));
        send_word(sample_word(0, 0));
        send_word(sample_word(300, -300));
        send_word(sample_word(600, -600));
        send_word(start_word(0, 0, 1000, 1000, LIMIT_MAX));
        send_word(sample_word(0, 0));
        send_word(sample_word(200, 250));
        send_word(sample_word(500, 400));
    endtask

    task automatic test_stall_end();
        wait_drained();
        write_reg(REG_STALL_LIMIT, 2);
        send_word(start_word(0, 0, 500, 500, 60));
        repeat (3) send_word(sample_word(0, 0));
        wait_drained();
        write_reg(REG_STALL_LIMIT, APB_DATA_WIDTH'(STALL_LIMIT_RST));
    endtask

    task automatic test_register_extremes();
        set_config(0, 0, 0, 0, 0, 1);
        send_word(start_word(0, 0, 300, -300, LIMIT_MAX));
        repeat (2) send_word(sample_word(0, 0));
        set_config(GAIN_MAX, GAIN_MAX, SLEW_MAX, SLEW_MAX, SETTLE_MAX, int'(STALL_MAX));
        send_word(start_word(0, 0, 300, -300, LIMIT_MAX));
        send_word(sample_word(10, -10));
        send_word(sample_word(20, -20));
    endtask

    task automatic test_random_phase(input int s_pct, input int r_pct, input int n);
        wait_drained();
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        random_config();
        run_moves(n / 2);
        random_config();
        run_moves(n - n / 2);
    endtask

    // Stall the receiver long enough that both stages fill and the input backs up
    task automatic test_output_holdoff();
        wait_drained();
        send_idle_pct = 0;
        hold_cycles   = HOLDOFF_CYCLES;
        run_moves(40);
        wait_drained();
    endtask

    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.cmd            = CMD_START;
        in_ch.left_position  = '0;
        in_ch.right_position = '0;
        in_ch.left_distance  = '0;
        in_ch.right_distance = '0;
        in_ch.drive_limit    = '0;
        mismatches           = 0;
        hold_cycles          = 0;
        send_idle_pct        = 21;
        recv_idle_pct        = 65;
        wheel_l              = '0;
        wheel_r              = '0;
        ctl_cfg              = '{GAIN_STRAIGHT_RST, GAIN_TURN_RST, SLEW_STRAIGHT_RST,
                                 SLEW_TURN_RST, SETTLE_BOUND_RST, STALL_LIMIT_RST};
        goal_l               = '0;
        goal_r               = '0;
        cap_now              = 0;
        limit_now            = 0;
        last_mean            = 0;
        same_count           = 0;
        moving               = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_sample();
        test_field_extremes();
        test_settle_at_once();
        test_turn_and_straight();
        test_stall_end();
        test_register_extremes();
        test_random_phase(21, 65, 260);
        test_random_phase(65, 21, 260);
        test_random_phase(0, 0, 200);
        test_output_holdoff();

        wait_drained();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
src/tdps_pkg.sv
src/tdps_if.sv
src/tdps_regs.sv
src/tdps_drive.sv
src/tdps_core.sv
src/tank_drive_p_slew_controller.sv
src/tdps_checker.sv
verif/tank_drive_p_slew_controller_test.sv
